FILE: src/slfs_pkg.sv
// Package for the sliding linear fit smoother: sizes, widths and the
// control/status structs passed between the window store and the core.
// No dependencies.
package slfs_pkg;

	localparam int MAX_WINDOW = 64;
	localparam int SAMPLE_W   = 16;
	localparam int OUT_W      = 18;
	localparam int LEN_W      = 7;
	localparam int ADDR_W     = $clog2(MAX_WINDOW);
	localparam int CNT_W      = $clog2(MAX_WINDOW + 1);

	// running sums over the window
	localparam int SY_W  = SAMPLE_W + CNT_W;
	localparam int SXY_W = SAMPLE_W + 2 * CNT_W;
	// reduced fit: num = 6*Sxy - 2*(n+1)*Sy, den = n*(n+1)
	localparam int NUM_W = SXY_W + 4;
	localparam int DEN_W = 2 * CNT_W + 1;
	// rounded quotient: (2*|num| + den) / (2*den)
	localparam int DVD_W = NUM_W + 1;
	localparam int DSR_W = DEN_W + 1;
	localparam int DIV_CW = $clog2(DVD_W);

	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(8);
	localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(2);
	localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_WINDOW);

	localparam logic [CNT_W-1:0]  FILL_FULL = CNT_W'(MAX_WINDOW);
	localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(MAX_WINDOW - 1);

	localparam logic signed [OUT_W-1:0] OUT_POS_SAT = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_NEG_SAT = {1'b1, {(OUT_W-1){1'b0}}};

	typedef struct packed {
		logic              wr_en;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
	} slfs_win_ctl_t;

	typedef struct packed {
		logic [CNT_W-1:0]  fill;
		logic [ADDR_W-1:0] wr_ptr;
	} slfs_win_sts_t;

endpackage

FILE: src/slfs_window.sv
// Sample ring for the sliding linear fit smoother: 64-entry memory with
// one write and one registered read port, plus write pointer and fill count.
// Depends on slfs_pkg.
module slfs_window (
	input  logic                          clk,
	input  logic                          arst_n,
	input  slfs_pkg::slfs_win_ctl_t       ctl,
	input  logic [slfs_pkg::SAMPLE_W-1:0] wr_data,
	output logic [slfs_pkg::SAMPLE_W-1:0] rd_data,
	output slfs_pkg::slfs_win_sts_t       sts
);

	logic [slfs_pkg::SAMPLE_W-1:0] mem_q [slfs_pkg::MAX_WINDOW];
	logic [slfs_pkg::SAMPLE_W-1:0] rd_data_q;
	logic [slfs_pkg::ADDR_W-1:0]   wr_ptr_q;
	logic [slfs_pkg::CNT_W-1:0]    fill_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem_q[ctl.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			fill_q   <= '0;
		end else if (ctl.wr_en) begin
			if (wr_ptr_q == slfs_pkg::LAST_SLOT) begin
				wr_ptr_q <= '0;
			end else begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (fill_q != slfs_pkg::FILL_FULL) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	assign rd_data    = rd_data_q;
	assign sts.fill   = fill_q;
	assign sts.wr_ptr = wr_ptr_q;

endmodule

FILE: src/slfs_divider.sv
// Restoring divider for the smoother: one quotient bit per cycle through a
// single shared subtractor. Unsigned dividend and divisor. Depends on slfs_pkg.
module slfs_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [slfs_pkg::DVD_W-1:0] dividend,
	input  logic [slfs_pkg::DSR_W-1:0] divisor,
	output logic                       done,
	output logic [slfs_pkg::DVD_W-1:0] quotient
);

	logic [slfs_pkg::DVD_W-1:0]  dq_q;   // dividend shifts out, quotient shifts in
	logic [slfs_pkg::DSR_W-1:0]  dsr_q;
	logic [slfs_pkg::DSR_W-1:0]  rem_q;
	logic [slfs_pkg::DIV_CW-1:0] cnt_q;
	logic                        busy_q;
	logic                        done_q;

	logic [slfs_pkg::DSR_W:0] rem_sh;
	logic [slfs_pkg::DSR_W:0] diff;
	logic                     qbit;

	always_comb begin
		rem_sh = {rem_q, dq_q[slfs_pkg::DVD_W-1]};
		diff   = rem_sh - {1'b0, dsr_q};
		qbit   = ~diff[slfs_pkg::DSR_W];
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dq_q <= {dq_q[slfs_pkg::DVD_W-2:0], qbit};
			if (qbit) begin
				rem_q <= diff[slfs_pkg::DSR_W-1:0];
			end else begin
				rem_q <= rem_sh[slfs_pkg::DSR_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= slfs_pkg::DIV_CW'(slfs_pkg::DVD_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

FILE: src/sliding_linear_fit_smoother_core.sv
// Sliding least-squares line smoother, top level: sequencer, sums and output.
// Steps from request to result (n = fitted samples, up to 64): n memory reads,
// then the sums settle, one numerator step, then the shared divider (load,
// quotient bits, capture), then the output register. One request at a time:
// in_stall stays high until the result is loaded into the output register.
// Reset clears control state; window length resets to 8, the sample memory is not cleared.
module sliding_linear_fit_smoother_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [slfs_pkg::LEN_W-1:0]         cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [slfs_pkg::SAMPLE_W-1:0] sample,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [slfs_pkg::OUT_W-1:0]  smoothed
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ACC   = 3'd1;
	localparam logic [2:0] ST_NUM   = 3'd2;
	localparam logic [2:0] ST_DIVGO = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]                         state_q;
	logic [slfs_pkg::LEN_W-1:0]         win_len_q;
	logic [slfs_pkg::CNT_W-1:0]         n_q;
	logic [slfs_pkg::CNT_W-1:0]         iss_q;
	logic [slfs_pkg::ADDR_W-1:0]        addr_q;
	logic                               rvld_s1;
	logic signed [slfs_pkg::SY_W-1:0]   sy_q;
	logic signed [slfs_pkg::SXY_W-1:0]  sxy_q;
	logic signed [slfs_pkg::NUM_W-1:0]  num_q;
	logic [slfs_pkg::DEN_W-1:0]         den_q;
	logic                               neg_q;
	logic [slfs_pkg::DVD_W-1:0]         quot_q;
	logic                               out_valid_q;
	logic signed [slfs_pkg::OUT_W-1:0]  smoothed_q;

	slfs_pkg::slfs_win_ctl_t            win_ctl;
	slfs_pkg::slfs_win_sts_t            win_sts;
	logic [slfs_pkg::SAMPLE_W-1:0]      rd_data;

	logic                               in_take;
	logic [slfs_pkg::LEN_W-1:0]         len_clamp;
	logic [slfs_pkg::CNT_W-1:0]         fill_next;
	logic [slfs_pkg::CNT_W-1:0]         n_next;
	logic signed [slfs_pkg::SY_W-1:0]   sy_new;
	logic [slfs_pkg::CNT_W:0]           np1;
	logic signed [slfs_pkg::NUM_W-1:0]  sxy_x;
	logic signed [slfs_pkg::NUM_W-1:0]  sy_x;
	logic signed [slfs_pkg::NUM_W-1:0]  wgt_x;
	logic signed [slfs_pkg::NUM_W-1:0]  num_d;
	logic [slfs_pkg::NUM_W-1:0]         mag;
	logic                               div_start;
	logic [slfs_pkg::DVD_W-1:0]         div_dvd;
	logic [slfs_pkg::DSR_W-1:0]         div_dsr;
	logic                               div_done;
	logic [slfs_pkg::DVD_W-1:0]         div_quot;
	logic signed [slfs_pkg::OUT_W-1:0]  sat_val;
	logic                               out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		if (win_len_q < slfs_pkg::LEN_MIN) begin
			len_clamp = slfs_pkg::LEN_MIN;
		end else if (win_len_q > slfs_pkg::LEN_MAX) begin
			len_clamp = slfs_pkg::LEN_MAX;
		end else begin
			len_clamp = win_len_q;
		end
		if (win_sts.fill == slfs_pkg::FILL_FULL) begin
			fill_next = win_sts.fill;
		end else begin
			fill_next = win_sts.fill + 1'b1;
		end
		if (slfs_pkg::LEN_W'(fill_next) < len_clamp) begin
			n_next = fill_next;
		end else begin
			n_next = slfs_pkg::CNT_W'(len_clamp);
		end
	end

	always_comb begin
		win_ctl.wr_en   = in_take;
		win_ctl.rd_en   = (state_q == ST_ACC) && (iss_q != n_q);
		win_ctl.rd_addr = addr_q;
	end

	slfs_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (win_ctl),
		.wr_data (sample),
		.rd_data (rd_data),
		.sts     (win_sts)
	);

	// Sxy is the sum of the running Sy taken newest to oldest
	assign sy_new = sy_q + slfs_pkg::SY_W'(signed'(rd_data));

	// v = round((6*Sxy - 2*(n+1)*Sy) / (n*(n+1)))
	always_comb begin
		np1   = {1'b0, n_q} + 1'b1;
		sxy_x = slfs_pkg::NUM_W'(sxy_q);
		sy_x  = slfs_pkg::NUM_W'(sy_q);
		wgt_x = {{(slfs_pkg::NUM_W-slfs_pkg::CNT_W-2){1'b0}}, np1, 1'b0};
		num_d = (sxy_x <<< 2) + (sxy_x <<< 1) - sy_x * wgt_x;
	end

	always_comb begin
		mag       = num_q[slfs_pkg::NUM_W-1] ? slfs_pkg::NUM_W'(-num_q)
		                                     : slfs_pkg::NUM_W'(num_q);
		div_start = (state_q == ST_DIVGO);
		div_dvd   = {mag, 1'b0} + slfs_pkg::DVD_W'(den_q);
		div_dsr   = {den_q, 1'b0};
	end

	slfs_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_comb begin
		if (!neg_q) begin
			if (quot_q > slfs_pkg::DVD_W'(slfs_pkg::OUT_POS_SAT)) begin
				sat_val = slfs_pkg::OUT_POS_SAT;
			end else begin
				sat_val = slfs_pkg::OUT_W'(quot_q);
			end
		end else begin
			if (quot_q > (slfs_pkg::DVD_W'(1) << (slfs_pkg::OUT_W - 1))) begin
				sat_val = slfs_pkg::OUT_NEG_SAT;
			end else begin
				sat_val = slfs_pkg::OUT_W'(-quot_q);
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			n_q    <= n_next;
			addr_q <= win_sts.wr_ptr;
			sy_q   <= '0;
			sxy_q  <= '0;
		end else if (rvld_s1) begin
			sy_q  <= sy_new;
			sxy_q <= sxy_q + slfs_pkg::SXY_W'(sy_new);
		end
		if (win_ctl.rd_en) begin
			if (addr_q == '0) begin
				addr_q <= slfs_pkg::LAST_SLOT;
			end else begin
				addr_q <= addr_q - 1'b1;
			end
		end
		if (state_q == ST_NUM) begin
			num_q <= num_d;
			den_q <= slfs_pkg::DEN_W'(n_q * np1);
		end
		if (div_start) begin
			neg_q <= num_q[slfs_pkg::NUM_W-1];
		end
		if (div_done) begin
			quot_q <= div_quot;
		end
		if (state_q == ST_DONE && out_free) begin
			smoothed_q <= sat_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			win_len_q   <= slfs_pkg::LEN_RESET;
			iss_q       <= '0;
			rvld_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				win_len_q <= cfg_wdata;
			end
			rvld_s1 <= win_ctl.rd_en;
			if (win_ctl.rd_en) begin
				iss_q <= iss_q + 1'b1;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						iss_q   <= '0;
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (iss_q == n_q && !rvld_s1) begin
						state_q <= ST_NUM;
					end
				end
				ST_NUM: begin
					state_q <= ST_DIVGO;
				end
				ST_DIVGO: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign smoothed  = smoothed_q;

endmodule

FILE: dv/linear_fit_checker.sv
// Checker for the sliding linear fit smoother: follows both channels and the config port,
// predicts each fitted endpoint and compares it with what the block returns.
// Depends on slfs_pkg.
module linear_fit_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [slfs_pkg::LEN_W-1:0]           cfg_wdata,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic signed [slfs_pkg::SAMPLE_W-1:0] sample,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic signed [slfs_pkg::OUT_W-1:0]    smoothed,
	output int                                   mismatches,
	output int                                   results_waiting
);

	logic signed [slfs_pkg::SAMPLE_W-1:0] ring [slfs_pkg::MAX_WINDOW];
	logic [slfs_pkg::ADDR_W-1:0]          write_slot;
	int                                   ring_fill;
	logic [slfs_pkg::LEN_W-1:0]           fit_length;
	logic signed [slfs_pkg::OUT_W-1:0]    expected_smoothed [$];
	logic signed [slfs_pkg::OUT_W-1:0]    want;

	// least-squares line over the newest n samples, evaluated at the newest position
	function automatic logic signed [slfs_pkg::OUT_W-1:0] fit_endpoint();
		longint n, span, sy, sxy, sx, sxx, num, den, mag, q;
		logic [slfs_pkg::ADDR_W-1:0] slot;
		span = fit_length;
		if (span < slfs_pkg::LEN_MIN) span = slfs_pkg::LEN_MIN;
		if (span > slfs_pkg::LEN_MAX) span = slfs_pkg::LEN_MAX;
		n = ring_fill;
		if (n > span) n = span;
		if (n <= 1) return ring[slfs_pkg::ADDR_W'(write_slot - 1)];
		sy = 0;
		sxy = 0;
		for (int k = 0; k < n; k++) begin
			slot = slfs_pkg::ADDR_W'(write_slot - 1 - k);
			sy += ring[slot];
			sxy += longint'(ring[slot]) * (n - k);
		end
		sx = n * (n + 1) / 2;
		sxx = n * (n + 1) * (2 * n + 1) / 6;
		num = sxy * (n * n - sx) + sy * (sxx - n * sx);
		den = n * sxx - sx * sx;
		// round half away from zero
		mag = (num < 0) ? -num : num;
		q = (2 * mag + den) / (2 * den);
		if (num < 0) q = -q;
		if (q > longint'(slfs_pkg::OUT_POS_SAT)) q = slfs_pkg::OUT_POS_SAT;
		if (q < longint'(slfs_pkg::OUT_NEG_SAT)) q = slfs_pkg::OUT_NEG_SAT;
		return slfs_pkg::OUT_W'(q);
	endfunction

	task automatic report_failure(input string what,
			input logic signed [slfs_pkg::OUT_W-1:0] exp_v,
			input logic signed [slfs_pkg::OUT_W-1:0] got_v);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_slot = '0;
			ring_fill = 0;
			fit_length = slfs_pkg::LEN_RESET;
			expected_smoothed.delete();
			results_waiting = 0;
			mismatches = 0;
		end else begin
			if (cfg_we)
				fit_length = cfg_wdata;
			if (in_valid && !in_stall) begin
				ring[write_slot] = sample;
				write_slot++;
				if (ring_fill < slfs_pkg::MAX_WINDOW)
					ring_fill++;
				expected_smoothed.push_back(fit_endpoint());
			end
			if (out_valid && !out_stall) begin
				if (expected_smoothed.size() == 0) begin
					report_failure("result with no request pending", 'x, smoothed);
				end else begin
					want = expected_smoothed.pop_front();
					if (smoothed !== want)
						report_failure("smoothed mismatch", want, smoothed);
				end
			end
			results_waiting = expected_smoothed.size();
		end
	end

endmodule

FILE: dv/sliding_linear_fit_smoother_core_tb.sv
// Top of the smoother testbench: clock, reset, sample and stall stimulus, window
// length changes and the verdict. Depends on slfs_pkg, linear_fit_checker and the core.
module sliding_linear_fit_smoother_core_tb;

	localparam int PHASES       = 12;
	localparam int PHASE_ITEMS  = 120;
	localparam int HOLD_CYCLES  = 600;
	localparam int DRAIN_CYCLES = 120;

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 cfg_we = 1'b0;
	logic [slfs_pkg::LEN_W-1:0]           cfg_wdata = '0;
	logic                                 in_valid = 1'b0;
	logic                                 in_stall;
	logic signed [slfs_pkg::SAMPLE_W-1:0] sample = '0;
	logic                                 out_valid;
	logic                                 out_stall = 1'b0;
	logic signed [slfs_pkg::OUT_W-1:0]    smoothed;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_requests = 0;
	int holds_served = 0;
	int ramp_level = 0;
	int ramp_step = 0;
	int mismatches;
	int results_waiting;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	sliding_linear_fit_smoother_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.smoothed  (smoothed)
	);

	linear_fit_checker fit_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.sample          (sample),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.smoothed        (smoothed),
		.mismatches      (mismatches),
		.results_waiting (results_waiting)
	);

	// receiver: random stalls, plus a long hold-off whenever the stimulus asks for one
	always begin
		@(negedge clk);
		if (hold_requests != holds_served) begin
			out_stall <= 1'b1;
			repeat (HOLD_CYCLES) @(negedge clk);
			holds_served++;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// called at a falling edge; returns at the falling edge after the request is taken,
	// with valid still high so back-to-back requests need no extra assignment
	task automatic offer_sample(input logic signed [slfs_pkg::SAMPLE_W-1:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample <= value;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// block must be idle: drop valid and wait until every result is back
	task automatic write_window_length(input logic [slfs_pkg::LEN_W-1:0] value);
		in_valid <= 1'b0;
		while (results_waiting != 0) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// noisy ramps and holds, mixed with full-range, extreme and small values
	function automatic logic signed [slfs_pkg::SAMPLE_W-1:0] random_sample();
		int pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0, 1, 2: begin
				ramp_level += ramp_step + int'($urandom_range(0, 200)) - 100;
				if (ramp_level > 32767 || ramp_level < -32768) begin
					ramp_level = (ramp_level > 0) ? 32767 : -32768;
					ramp_step = -ramp_step;
				end
				return slfs_pkg::SAMPLE_W'(ramp_level);
			end
			3, 4: return slfs_pkg::SAMPLE_W'($urandom);
			5: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			6, 7: return slfs_pkg::SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
			8: return slfs_pkg::SAMPLE_W'(ramp_level);
			default: return $urandom_range(0, 1)
				? slfs_pkg::SAMPLE_W'(32767 - int'($urandom_range(0, 255)))
				: slfs_pkg::SAMPLE_W'(-32768 + int'($urandom_range(0, 255)));
		endcase
	endfunction

	initial begin : stimulus
		logic signed [slfs_pkg::SAMPLE_W-1:0] opening [23];
		logic [slfs_pkg::LEN_W-1:0]           span;
		// fill from reset at the default length: pass-through, two-point fit,
		// a positive rounding tie at three points, rails and steps
		opening = '{16'sh8000, 16'sh7FFF, 16'sd1, -16'sd1, 16'sd0,
			16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
			16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
			16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd21845};
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (opening[i])
			offer_sample(opening[i]);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: span = slfs_pkg::LEN_MAX;
				1: span = 7'd0;
				2: span = 7'd1;
				3: span = slfs_pkg::LEN_MIN;
				4: span = 7'd127;
				5: span = 7'd65;
				6: span = 7'd3;
				7: span = 7'd17;
				8: span = slfs_pkg::LEN_RESET;
				9: span = 7'd33;
				10: span = 7'd63;
				default: span = 7'd5;
			endcase
			case (p % 4)
				0: begin
					send_idle_pct <= 0;
					stall_pct <= 0;
				end
				1: begin
					send_idle_pct <= 65;
					stall_pct <= 0;
				end
				2: begin
					send_idle_pct <= 0;
					stall_pct <= 65;
				end
				default: begin
					send_idle_pct <= 21;
					stall_pct <= 21;
				end
			endcase
			write_window_length(span);
			ramp_step = int'($urandom_range(0, 400)) - 200;
			// rounding ties in both directions over a three-sample fit
			if (span == 7'd3) begin
				offer_sample(16'sd0);
				offer_sample(16'sd0);
				offer_sample(-16'sd3);
				offer_sample(16'sd0);
				offer_sample(16'sd0);
				offer_sample(16'sd3);
			end
			// long output hold-off while requests keep coming
			if (p == 2)
				hold_requests <= hold_requests + 1;
			repeat (PHASE_ITEMS)
				offer_sample(random_sample());
		end

		in_valid <= 1'b0;
		while (results_waiting != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && results_waiting == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#3000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
